// File: hdl/dkdt_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// debounced key tone generator. No dependencies.
package dkdt_pkg;

  localparam int NUM_KEYS  = 7;
  localparam int KEY_IDX_W = 3;
  localparam int CNT_W     = 3;
  localparam int STEP_W    = 28;
  localparam int DAC_W     = 16;
  localparam int LEVEL_W   = 12;

  localparam int SHORT_HISTORY_DEF = 8;
  localparam int LONG_HISTORY_DEF  = 10;
  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int PHASE_BITS_DEF    = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam longint unsigned SAMPLE_RATE_HZ = 64'd25000;
  localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
  localparam longint unsigned SINE_AMPL      = 64'd2047;
  localparam logic [3:0]      DAC_CMD_A      = 4'h3;

  typedef enum logic {
    REQ_KEY_SCAN    = 1'b0,
    REQ_SAMPLE_TICK = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [NUM_KEYS-1:0]   pressed;
    logic [CNT_W-1:0]      count;
    logic [KEY_IDX_W-1:0]  hi_key;
    logic [KEY_IDX_W-1:0]  lo_key;
  } key_item_t;

  function automatic longint unsigned note_hz(int unsigned key);
    longint unsigned f;
    unique case (key)
      0:       f = 64'd698;
      1:       f = 64'd784;
      2:       f = 64'd880;
      3:       f = 64'd988;
      4:       f = 64'd1047;
      5:       f = 64'd1175;
      6:       f = 64'd1319;
      default: f = 64'd0;
    endcase
    return f;
  endfunction

  function automatic longint unsigned note_step(int unsigned key, int unsigned phase_bits);
    return (note_hz(key) << phase_bits) / SAMPLE_RATE_HZ;
  endfunction

  // Offset-binary DAC level for table entry k of a 2**lg entry table.
  function automatic logic [LEVEL_W-1:0] sine_level(int unsigned k, int unsigned lg);
    longint unsigned d;
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          sum;
    longint          s;
    logic            neg;
    d   = 64'd1 << lg;
    a   = 64'd4 * longint'(k);
    neg = 1'b0;
    if (a > 2 * d) begin
      neg = 1'b1;
      a   = 4 * d - a;
    end
    if (a > d) begin
      a = 2 * d - a;
    end
    if (a == 0) begin
      mag = 0;
    end else if (a == d) begin
      mag = SINE_AMPL;
    end else begin
      x    = (HALF_PI_Q30 * a) >> lg;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x2) >> 30;
        unique case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          7:       term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      mag = (SINE_AMPL * longint'(sum)) >> 30;
      if (mag > SINE_AMPL) begin
        mag = SINE_AMPL;
      end
    end
    s = neg ? -longint'(mag) : longint'(mag);
    s = s + 2048;
    return s[LEVEL_W-1:0];
  endfunction

endpackage

// File: hdl/debounced_keys_to_dds_tone_top.sv
// Debounced key tone generator top: front end, queue, DDS back end.
// An accepted item passes the queue, the b stage and the output register in turn.
// Throughput: one transaction per cycle (one queue pop) unless out_ready stalls.
// Reset (synchronous, active low) clears key history, phase, step and all valids.
// Depends on dkdt_pkg, dkdt_front, dkdt_queue, dkdt_back.
module debounced_keys_to_dds_tone_top #(
  parameter int SHORT_HISTORY = dkdt_pkg::SHORT_HISTORY_DEF,
  parameter int LONG_HISTORY  = dkdt_pkg::LONG_HISTORY_DEF,
  parameter int TABLE_DEPTH   = dkdt_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_BITS    = dkdt_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [dkdt_pkg::NUM_KEYS-1:0] in_key_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dkdt_pkg::DAC_W-1:0]    out_dac_word,
  output logic [dkdt_pkg::NUM_KEYS-1:0] out_pressed_keys,
  output logic [dkdt_pkg::CNT_W-1:0]    out_note_count,
  output logic [dkdt_pkg::STEP_W-1:0]   out_main_step,
  output logic [dkdt_pkg::STEP_W-1:0]   out_second_step
);
  import dkdt_pkg::*;

  logic      q_push;
  logic      q_ready;
  logic      q_pop;
  logic      q_valid;
  key_item_t q_item;
  key_item_t q_head;

  dkdt_front #(
    .SHORT_HISTORY (SHORT_HISTORY),
    .LONG_HISTORY  (LONG_HISTORY)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_key_levels (in_key_levels),
    .q_push        (q_push),
    .q_item        (q_item),
    .q_ready       (q_ready)
  );

  dkdt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_item  (q_item),
    .q_ready (q_ready),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  dkdt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dac_word     (out_dac_word),
    .out_pressed_keys (out_pressed_keys),
    .out_note_count   (out_note_count),
    .out_main_step    (out_main_step),
    .out_second_step  (out_second_step)
  );

endmodule

// File: hdl/dkdt_front.sv
// Front end: accepts transactions, debounces key scans and classifies them.
// Depends on dkdt_pkg.
module dkdt_front #(
  parameter int SHORT_HISTORY = dkdt_pkg::SHORT_HISTORY_DEF,
  parameter int LONG_HISTORY  = dkdt_pkg::LONG_HISTORY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [dkdt_pkg::NUM_KEYS-1:0] in_key_levels,
  output logic                          q_push,
  output dkdt_pkg::key_item_t           q_item,
  input  logic                          q_ready
);
  import dkdt_pkg::*;

  localparam int HIST_W = (LONG_HISTORY > SHORT_HISTORY) ? LONG_HISTORY : SHORT_HISTORY;

  logic [HIST_W-1:0]    hist_r   [NUM_KEYS];
  logic [HIST_W-1:0]    hist_nxt [NUM_KEYS];
  logic [NUM_KEYS-1:0]  pressed;
  logic [CNT_W-1:0]     cnt;
  logic [KEY_IDX_W-1:0] hi_key;
  logic [KEY_IDX_W-1:0] lo_key;
  req_type_t            req;

  assign req      = req_type_t'(in_req_type);
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
    localparam int NEED = (g == NUM_KEYS - 1) ? LONG_HISTORY : SHORT_HISTORY;
    assign pressed[g]  = !in_key_levels[g] && (hist_r[g][NEED-1:0] == '0);
    assign hist_nxt[g] = HIST_W'({hist_r[g], in_key_levels[g]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hist_r[g] <= '0;
      end else if (q_push && req == REQ_KEY_SCAN) begin
        hist_r[g] <= hist_nxt[g];
      end
    end
  end

  always_comb begin
    cnt    = '0;
    hi_key = '0;
    lo_key = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (pressed[k]) begin
        if (cnt == '0) begin
          lo_key = KEY_IDX_W'(k);
        end
        hi_key = KEY_IDX_W'(k);
        cnt    = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    q_item.req_type = req;
    q_item.pressed  = pressed;
    q_item.count    = cnt;
    q_item.hi_key   = hi_key;
    q_item.lo_key   = lo_key;
  end

endmodule

// File: hdl/dkdt_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on dkdt_pkg.
module dkdt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_push,
  input  dkdt_pkg::key_item_t q_item,
  output logic                q_ready,
  input  logic                q_pop,
  output logic                q_valid,
  output dkdt_pkg::key_item_t q_head
);
  import dkdt_pkg::*;

  key_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign q_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_item;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> cnt_r != QCNT_W'(QUEUE_DEPTH))
    else $error("queue push while full");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("queue pop while empty");

endmodule

// File: hdl/dkdt_back.sv
// Back end: note step selection, phase accumulator, sine ROM and result register.
// Depends on dkdt_pkg.
module dkdt_back #(
  parameter int TABLE_DEPTH = dkdt_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = dkdt_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  dkdt_pkg::key_item_t           q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dkdt_pkg::DAC_W-1:0]    out_dac_word,
  output logic [dkdt_pkg::NUM_KEYS-1:0] out_pressed_keys,
  output logic [dkdt_pkg::CNT_W-1:0]    out_note_count,
  output logic [dkdt_pkg::STEP_W-1:0]   out_main_step,
  output logic [dkdt_pkg::STEP_W-1:0]   out_second_step
);
  import dkdt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [LEVEL_W-1:0]    sine_tab [TABLE_DEPTH];
  logic [PHASE_BITS-1:0] step_tab [NUM_KEYS];

  logic                  en;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [PHASE_BITS-1:0] active_step_r;
  logic [PHASE_BITS-1:0] main_nxt;
  logic [PHASE_BITS-1:0] second_nxt;
  logic                  is_tick;

  logic                  b_valid_r;
  req_type_t             b_type_r;
  logic [NUM_KEYS-1:0]   b_pressed_r;
  logic [CNT_W-1:0]      b_count_r;
  logic [STEP_W-1:0]     b_main_r;
  logic [STEP_W-1:0]     b_second_r;
  logic [IDX_W-1:0]      b_idx_r;

  logic                  out_valid_r;
  logic [DAC_W-1:0]      out_dac_r;
  logic [NUM_KEYS-1:0]   out_pressed_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [STEP_W-1:0]     out_main_r;
  logic [STEP_W-1:0]     out_second_r;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    assign sine_tab[g] = sine_level(g, IDX_W);
  end
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_step
    assign step_tab[g] = PHASE_BITS'(note_step(g, PHASE_BITS));
  end

  assign en      = !out_valid_r || out_ready;
  assign q_pop   = en && q_valid;
  assign is_tick = (q_head.req_type == REQ_SAMPLE_TICK);

  assign phase_nxt = phase_r + active_step_r;

  always_comb begin
    main_nxt   = '0;
    second_nxt = '0;
    if (q_head.count == CNT_W'(1) || q_head.count == CNT_W'(2)) begin
      main_nxt = step_tab[q_head.hi_key];
    end
    if (q_head.count == CNT_W'(2)) begin
      second_nxt = step_tab[q_head.lo_key];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      active_step_r <= '0;
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      b_valid_r   <= q_pop;
      out_valid_r <= b_valid_r;
      if (q_pop) begin
        if (is_tick) begin
          phase_r <= phase_nxt;
        end else begin
          active_step_r <= main_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_pop) begin
        b_type_r    <= q_head.req_type;
        b_pressed_r <= is_tick ? '0 : q_head.pressed;
        b_count_r   <= is_tick ? '0 : q_head.count;
        b_main_r    <= is_tick ? '0 : STEP_W'(main_nxt);
        b_second_r  <= is_tick ? '0 : STEP_W'(second_nxt);
        b_idx_r     <= phase_nxt[PHASE_BITS-1 -: IDX_W];
      end
      out_dac_r     <= (b_type_r == REQ_SAMPLE_TICK) ? {DAC_CMD_A, sine_tab[b_idx_r]} : '0;
      out_pressed_r <= b_pressed_r;
      out_count_r   <= b_count_r;
      out_main_r    <= b_main_r;
      out_second_r  <= b_second_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_word     = out_dac_r;
  assign out_pressed_keys = out_pressed_r;
  assign out_note_count   = out_count_r;
  assign out_main_step    = out_main_r;
  assign out_second_step  = out_second_r;

  a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dac_r != '0 |-> out_pressed_r == '0 && out_count_r == '0
      && out_main_r == '0)
    else $error("sample result carries key fields");
  a_second_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_second_r != '0 |-> out_count_r == CNT_W'(2))
    else $error("second step without a key pair");
  a_main_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_main_r != '0 |-> out_count_r == CNT_W'(1) || out_count_r == CNT_W'(2))
    else $error("main step with wrong key count");

endmodule
